### sv/idiv64_pkg.sv
// ----------------------------------------------------------------------------
// idiv64_pkg
// types and constants shared by the 64-bit divider modules
// ----------------------------------------------------------------------------
package idiv64_pkg;

    localparam int DATA_W = 64;
    localparam int STEPS  = DATA_W;
    localparam int CNT_W  = $clog2(STEPS);

    typedef enum logic [1:0] {
        OP_UQUO = 2'd0,
        OP_UREM = 2'd1,
        OP_SQUO = 2'd2,
        OP_SREM = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              zero_divisor;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
    } t_dp_status;

endpackage

### sv/idiv64_dp.sv
// ----------------------------------------------------------------------------
// idiv64_dp
// operand magnitudes, radix-2 restoring shift-subtract loop and sign fix-up
// ----------------------------------------------------------------------------
module idiv64_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  idiv64_pkg::t_dp_cmd    i_cmd,
    input  idiv64_pkg::t_in_word   i_word,
    output idiv64_pkg::t_dp_status o_status,
    output idiv64_pkg::t_out_word  o_word
);
    import idiv64_pkg::*;

    t_op               r_op;
    logic              r_a_neg;
    logic              r_b_neg;
    logic              r_zero;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    t_out_word         r_out;

    logic              in_signed;
    logic              a_neg;
    logic              b_neg;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              qbit;
    logic [DATA_W-1:0] quo_sel;
    logic [DATA_W-1:0] pre_res;
    logic              do_neg;
    logic [DATA_W-1:0] res;

    assign in_signed = (i_word.op == OP_SQUO) || (i_word.op == OP_SREM);
    assign a_neg     = in_signed & i_word.dividend[DATA_W-1];
    assign b_neg     = in_signed & i_word.divisor[DATA_W-1];
    assign a_mag     = a_neg ? (DATA_W'(0) - i_word.dividend) : i_word.dividend;
    assign b_mag     = b_neg ? (DATA_W'(0) - i_word.divisor) : i_word.divisor;

    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign qbit    = ~diff[DATA_W];

    // zero divisor: remainder already ends as the dividend magnitude
    assign quo_sel = r_zero ? '0 : r_quo;

    always_comb begin
        case (r_op)
            OP_UQUO: begin
                pre_res = quo_sel;
                do_neg  = 1'b0;
            end
            OP_UREM: begin
                pre_res = r_rem;
                do_neg  = 1'b0;
            end
            OP_SQUO: begin
                pre_res = quo_sel;
                do_neg  = r_a_neg ^ r_b_neg;
            end
            OP_SREM: begin
                pre_res = r_rem;
                do_neg  = r_a_neg;
            end
            default: begin
                pre_res = r_rem;
                do_neg  = 1'b0;
            end
        endcase
    end

    assign res = do_neg ? (DATA_W'(0) - pre_res) : pre_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_word.op;
            r_a_neg <= a_neg;
            r_b_neg <= b_neg;
            r_zero  <= (i_word.divisor == '0);
            r_quo   <= a_mag;
            r_den   <= b_mag;
            r_rem   <= '0;
        end else if (i_cmd.step) begin
            r_rem <= qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], qbit};
        end
        if (i_cmd.finish) begin
            r_out.result       <= res;
            r_out.zero_divisor <= r_zero;
        end
    end

    assign o_status.last_step = (r_cnt == CNT_W'(STEPS - 1));
    assign o_word             = r_out;

    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cnt == '0))
        else $error("step counter not cleared on load");

    a_cnt_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("step counter did not advance");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load && (r_den != '0) && (r_rem < r_den))
        |=> (r_rem < r_den))
        else $error("partial remainder exceeds divisor");

endmodule

### sv/idiv64_ctrl.sv
// ----------------------------------------------------------------------------
// idiv64_ctrl
// sequencer for load, iteration and fix-up, plus result word valid
// ----------------------------------------------------------------------------
module idiv64_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    input  idiv64_pkg::t_dp_status i_status,
    output idiv64_pkg::t_dp_cmd    o_cmd
);
    import idiv64_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.last_step) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_load_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_RUN))
        else $error("accepted word did not start iteration");

    a_run_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && i_status.last_step) |=> (r_state == S_FIX))
        else $error("last step did not lead to fix-up");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> out_free)
        else $error("result word overwritten while pending");

endmodule

### sv/int64_divider_signed_unsigned_top.sv
// ----------------------------------------------------------------------------
// int64_divider_signed_unsigned_top
// 64-bit signed and unsigned divider returning quotient or remainder
//
//   channel | valid   | stall   | word
//   input   | i_valid | o_stall | i_data (op, dividend, divisor)
//   output  | o_valid | i_stall | o_data (result, zero_divisor)
//
// one word at a time, in order: load, 64 shift-subtract steps, fix-up
// the iteration count is set by the radix-2 restoring loop in the datapath
// the result register lets the next word load while a result waits
// fix-up waits while the previous result is still stalled
// synchronous active-low reset clears the sequencer and result valid
// ----------------------------------------------------------------------------
module int64_divider_signed_unsigned_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  idiv64_pkg::t_in_word  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output idiv64_pkg::t_out_word o_data
);
    import idiv64_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    idiv64_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    idiv64_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_word   (i_data),
        .o_status (status),
        .o_word   (o_data)
    );

endmodule

### sim/tb_int64_divider_signed_unsigned_top.sv
// ----------------------------------------------------------------------------
// tb_int64_divider_signed_unsigned_top
// self-checking bench for the 64-bit signed and unsigned divider
//
// words are sent through the valid/stall input channel with random gaps and
// results are taken with random stalls; every accepted word is divided by a
// bench-side model and the expected result is queued, and each result that
// leaves the block is checked against the oldest entry. covered: operand
// extremes on all four operations, a long hold on the output so the block
// backs up, drained pauses on the input and a long random run
// ----------------------------------------------------------------------------
module tb_int64_divider_signed_unsigned_top;
    timeunit 1ns;
    timeprecision 1ps;

    import idiv64_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 100;
    localparam int RANDOM_WORDS = 1100;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_word  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_data;

    t_out_word pending_results[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    int        tx_gap_max  = 12;
    int        rx_stall_max = 12;
    int        rx_hold_len = 0;

    int64_divider_signed_unsigned_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #4ns i_clk = 1'b1;
        #4ns i_clk = 1'b0;
    end

    function automatic t_out_word divide_word(t_in_word w);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        logic        num_neg;
        logic        den_neg;
        logic        is_signed;
        t_out_word   r;
        is_signed = (w.op == OP_SQUO) || (w.op == OP_SREM);
        num_neg   = is_signed && w.dividend[63];
        den_neg   = is_signed && w.divisor[63];
        num = num_neg ? 64'd0 - w.dividend : w.dividend;
        den = den_neg ? 64'd0 - w.divisor : w.divisor;
        if (den == 64'd0) begin
            quo = 64'd0;
            rem = num;
        end else begin
            quo = num / den;
            rem = num % den;
        end
        case (w.op)
            OP_UQUO: r.result = quo;
            OP_UREM: r.result = rem;
            OP_SQUO: r.result = (num_neg != den_neg) ? 64'd0 - quo : quo;
            default: r.result = num_neg ? 64'd0 - rem : rem;
        endcase
        r.zero_divisor = (w.divisor == 64'd0);
        return r;
    endfunction

    // mix of extremes, narrow values and full-width noise
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = 64'd1;
            2: v = '1;
            3: v = 64'h8000_0000_0000_0000;
            4: v = 64'h7fff_ffff_ffff_ffff;
            5, 6: v = v >> $urandom_range(1, 63);
            7: v = 64'd0 - (v >> $urandom_range(1, 63));
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic send_word(input t_op op, input logic [63:0] a, input logic [63:0] b);
        t_in_word w;
        int       gap;
        w.op       = op;
        w.dividend = a;
        w.divisor  = b;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(divide_word(w));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [63:0] dividends[6];
        logic [63:0] divisors[6];
        dividends = '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '1,
                      64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fff9, 64'd13};
        divisors  = '{64'd0, '1, 64'h8000_0000_0000_0000,
                      64'd3, 64'd2, 64'hffff_ffff_ffff_fffb};
        for (int i = 0; i < 6; i++) begin
            send_word(OP_UQUO, dividends[i], divisors[i]);
            send_word(OP_UREM, dividends[i], divisors[i]);
            send_word(OP_SQUO, dividends[i], divisors[i]);
            send_word(OP_SREM, dividends[i], divisors[i]);
        end
        wait_drained();
    endtask

    task automatic test_output_hold();
        tx_gap_max  = 0;
        rx_hold_len = 400;
        for (int i = 0; i < 10; i++) begin
            send_word(t_op'($urandom_range(0, 3)), pick_operand(), pick_operand());
        end
        wait_drained();
        tx_gap_max = 12;
    endtask

    task automatic test_input_pause();
        for (int n = 0; n < 3; n++) begin
            for (int i = 0; i < 20; i++) begin
                send_word(t_op'($urandom_range(0, 3)), pick_operand(), pick_operand());
            end
            wait_drained();
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // a stretch with no idling on either side
            if (i == RANDOM_WORDS / 3) begin
                tx_gap_max   = 0;
                rx_stall_max = 0;
            end else if (i == RANDOM_WORDS / 2) begin
                tx_gap_max   = 12;
                rx_stall_max = 12;
            end
            send_word(t_op'($urandom_range(0, 3)), pick_operand(), pick_operand());
        end
        wait_drained();
    endtask

    // result side: random stall before each word, long hold on request
    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            if (rx_hold_len > 0) begin
                n = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                n = $urandom_range(0, rx_stall_max);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_data.result));
            end else begin
                if (o_data.result !== pending_results[0].result)
                    report_mismatch($sformatf("result %h, expected %h",
                        o_data.result, pending_results[0].result));
                if (o_data.zero_divisor !== pending_results[0].zero_divisor)
                    report_mismatch($sformatf("zero_divisor %b, expected %b",
                        o_data.zero_divisor, pending_results[0].zero_divisor));
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_output_hold();
        test_input_pause();
        test_random();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
